// ----- rtl/dlefr_pkg.sv -----
// Shared types and constants for the DLE frame receiver and parser.
// Used by every module of the block; depends on nothing else.

package dlefr_pkg;

  localparam int unsigned HEADER_BYTES   = 6;
  localparam int unsigned FOOTER_BYTES   = 6;
  localparam int unsigned COUNT_W        = 9;
  localparam int unsigned CMD_FIFO_DEPTH = 2;
  localparam int unsigned CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
  localparam int unsigned CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);
  localparam int unsigned HDR_IDX_W      = $clog2(HEADER_BYTES);
  localparam int unsigned OUT_TDATA_W    = 120;
  localparam int unsigned OUT_TUSER_W    = 3;

  localparam logic [7:0] SYM_DLE = 8'h10;
  localparam logic [7:0] SYM_STX = 8'h02;
  localparam logic [7:0] SYM_ETX = 8'h03;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_START,
    CMD_END,
    CMD_ABORT
  } cmd_op_e;

  typedef enum logic [2:0] {
    KIND_PAYLOAD      = 3'd0,
    KIND_DONE         = 3'd1,
    KIND_SHORT_HEADER = 3'd2,
    KIND_PART_FOOTER  = 3'd3,
    KIND_BAD_ESCAPE   = 3'd4
  } kind_e;

  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] data;
  } cmd_t;

endpackage

// ----- rtl/dle_frame_receiver_parser.sv -----
// Top level of the DLE/STX/ETX frame receiver and parser.
// A result word is registered: each command passes the command queue, then the output register of the builder.
// Throughput: one byte per cycle while the output is accepted; a stalled output fills
// the two-entry command queue, after which the input is held off until it drains.
// Reset (asynchronous, active low) leaves the block outside any frame, queue empty.
// Depends on dlefr_pkg, dlefr_escape_decoder, dlefr_cmd_fifo and dlefr_frame_builder.

module dle_frame_receiver_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] rx_byte
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [7:0] payload_byte, [15:8] payload_index, [23:16] src_addr, [31:24] dst_addr,
  // [39:32] pkt_type, [47:40] pkt_status, [55:48] seq_num, [63:56] payload_len,
  // [64] footer_valid, [112:65] footer_word, [119:113] zero
  output logic [119:0]  m_axis_tdata,
  output logic [2:0]    m_axis_tuser    // [2:0] kind
);

  dlefr_pkg::cmd_t front_cmd, back_cmd;
  logic            cmd_push, cmd_full, cmd_valid, cmd_pop;

  dlefr_escape_decoder u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_i       (s_axis_tdata),
    .cmd_full_i   (cmd_full),
    .byte_ready_o (s_axis_tready),
    .cmd_push_o   (cmd_push),
    .cmd_o        (front_cmd)
  );

  dlefr_cmd_fifo u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_push),
    .push_cmd_i (front_cmd),
    .full_o     (cmd_full),
    .pop_i      (cmd_pop),
    .valid_o    (cmd_valid),
    .pop_cmd_o  (back_cmd)
  );

  dlefr_frame_builder u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser)
  );

endmodule

// ----- rtl/dlefr_escape_decoder.sv -----
// Front end: removes DLE stuffing and turns raw bytes into frame commands.
// Depends on dlefr_pkg.

module dlefr_escape_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  input  logic [7:0]          byte_i,
  input  logic                cmd_full_i,
  output logic                byte_ready_o,
  output logic                cmd_push_o,
  output dlefr_pkg::cmd_t     cmd_o
);

  logic in_frame_q, in_frame_d;
  logic escape_q, escape_d;
  logic accept;
  logic push;

  assign byte_ready_o = !cmd_full_i;
  assign accept       = byte_valid_i && !cmd_full_i;
  assign cmd_push_o   = accept && push;

  always_comb begin
    in_frame_d   = in_frame_q;
    escape_d     = escape_q;
    push         = 1'b0;
    cmd_o.op     = dlefr_pkg::CMD_DATA;
    cmd_o.data   = byte_i;
    if (escape_q) begin
      escape_d = 1'b0;
      if (byte_i == dlefr_pkg::SYM_STX) begin
        in_frame_d = 1'b1;
        push       = 1'b1;
        cmd_o.op   = dlefr_pkg::CMD_START;
      end else if (in_frame_q) begin
        push = 1'b1;
        if (byte_i == dlefr_pkg::SYM_DLE) begin
          cmd_o.op = dlefr_pkg::CMD_DATA;
        end else if (byte_i == dlefr_pkg::SYM_ETX) begin
          in_frame_d = 1'b0;
          cmd_o.op   = dlefr_pkg::CMD_END;
        end else begin
          in_frame_d = 1'b0;
          cmd_o.op   = dlefr_pkg::CMD_ABORT;
        end
      end
    end else if (byte_i == dlefr_pkg::SYM_DLE) begin
      escape_d = 1'b1;
    end else if (in_frame_q) begin
      push = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      escape_q   <= 1'b0;
    end else if (accept) begin
      in_frame_q <= in_frame_d;
      escape_q   <= escape_d;
    end
  end

endmodule

// ----- rtl/dlefr_cmd_fifo.sv -----
// Short command queue between the escape decoder and the frame builder.
// Depends on dlefr_pkg.

module dlefr_cmd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dlefr_pkg::cmd_t  push_cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output dlefr_pkg::cmd_t  pop_cmd_o
);

  dlefr_pkg::cmd_t                  mem_q [dlefr_pkg::CMD_FIFO_DEPTH];
  logic [dlefr_pkg::CMD_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [dlefr_pkg::CMD_CNT_W-1:0]  count_q;
  logic                             do_push, do_pop;

  assign full_o    = count_q == dlefr_pkg::CMD_CNT_W'(dlefr_pkg::CMD_FIFO_DEPTH);
  assign valid_o   = count_q != '0;
  assign pop_cmd_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + dlefr_pkg::CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - dlefr_pkg::CMD_CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/dlefr_frame_builder.sv -----
// Back end: captures header and footer, emits payload and summary words
// through a registered output stage. Depends on dlefr_pkg.

module dlefr_frame_builder (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cmd_valid_i,
  input  dlefr_pkg::cmd_t                       cmd_i,
  output logic                                  cmd_pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [dlefr_pkg::OUT_TDATA_W-1:0]     out_data_o,
  output logic [dlefr_pkg::OUT_TUSER_W-1:0]     out_kind_o
);

  localparam int unsigned CW = dlefr_pkg::COUNT_W;

  logic [CW-1:0]    count_q, count_d;
  logic [7:0]       hdr_q [dlefr_pkg::HEADER_BYTES];
  logic [47:0]      footer_q, footer_d;
  logic             hdr_we, hdr_clr;
  logic             out_valid_q;
  logic [dlefr_pkg::OUT_TDATA_W-1:0] out_data_q;
  dlefr_pkg::kind_e out_kind_q;

  logic             take;
  logic             emit;
  dlefr_pkg::kind_e kind;
  logic [7:0]       pbyte, pidx;
  logic             fvalid;
  logic [47:0]      fword;
  logic [7:0]       len;
  logic [CW-1:0]    pay_end, foot_end, got;

  assign take      = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_pop_o = take;
  assign len       = hdr_q[dlefr_pkg::HEADER_BYTES-1];
  assign pay_end   = CW'(dlefr_pkg::HEADER_BYTES) + CW'(len);
  assign foot_end  = pay_end + CW'(dlefr_pkg::FOOTER_BYTES);
  assign got       = count_q - pay_end;

  always_comb begin
    count_d  = count_q;
    footer_d = footer_q;
    hdr_we   = 1'b0;
    hdr_clr  = 1'b0;
    emit     = 1'b0;
    kind     = dlefr_pkg::KIND_DONE;
    pbyte    = '0;
    pidx     = '0;
    fvalid   = 1'b0;
    fword    = '0;
    unique case (cmd_i.op)
      dlefr_pkg::CMD_START: begin
        count_d  = '0;
        footer_d = '0;
        hdr_clr  = 1'b1;
      end
      dlefr_pkg::CMD_DATA: begin
        if (count_q < CW'(dlefr_pkg::HEADER_BYTES)) begin
          hdr_we  = 1'b1;
          count_d = count_q + CW'(1);
        end else if (count_q < pay_end) begin
          emit    = 1'b1;
          kind    = dlefr_pkg::KIND_PAYLOAD;
          pbyte   = cmd_i.data;
          pidx    = 8'(count_q - CW'(dlefr_pkg::HEADER_BYTES));
          count_d = count_q + CW'(1);
        end else if (len != '0 && count_q < foot_end) begin
          footer_d = {footer_q[39:0], cmd_i.data};
          count_d  = count_q + CW'(1);
        end
      end
      dlefr_pkg::CMD_END: begin
        emit = 1'b1;
        if (count_q < CW'(dlefr_pkg::HEADER_BYTES)) begin
          kind = dlefr_pkg::KIND_SHORT_HEADER;
        end else if (len != '0 && count_q > pay_end) begin
          if (got < CW'(dlefr_pkg::FOOTER_BYTES)) begin
            kind = dlefr_pkg::KIND_PART_FOOTER;
          end else begin
            fvalid = 1'b1;
            fword  = footer_q;
          end
        end
      end
      dlefr_pkg::CMD_ABORT: begin
        emit = 1'b1;
        kind = dlefr_pkg::KIND_BAD_ESCAPE;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      footer_q <= footer_d;
      if (hdr_clr) begin
        for (int i = 0; i < dlefr_pkg::HEADER_BYTES; i++) begin
          hdr_q[i] <= '0;
        end
      end else if (hdr_we) begin
        hdr_q[count_q[dlefr_pkg::HDR_IDX_W-1:0]] <= cmd_i.data;
      end
      if (emit) begin
        out_kind_q <= kind;
        out_data_q <= {7'b0, fword, fvalid, hdr_q[5], hdr_q[4], hdr_q[3], hdr_q[2],
                       hdr_q[1], hdr_q[0], pidx, pbyte};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        count_q <= count_d;
      end
      if (take) begin
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_kind_o  = out_kind_q;

endmodule

// ----- bench/dle_frame_receiver_parser_tb.sv -----
// Self-checking testbench for the DLE/STX/ETX frame receiver and parser.
// A directed byte table and random frames are checked against a behavioural deframer.
// Depends on dlefr_pkg and dle_frame_receiver_parser.
`timescale 1ns / 100ps

module dle_frame_receiver_parser_tb;
  import dlefr_pkg::*;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pay_byte;
    logic [7:0]  pay_idx;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [7:0]  ptype;
    logic [7:0]  pstat;
    logic [7:0]  seq;
    logic [7:0]  plen;
    logic        fvalid;
    logic [47:0] fword;
  } frame_res_t;

  typedef struct {
    logic [7:0] rx;
    bit         typed;
    frame_res_t res;
  } stim_row_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  stim_row_t  byte_q[$];
  stim_row_t  cur_row;
  frame_res_t frame_res_q[$];
  int         err_cnt  = 0;
  int         hold_req = 0;

  logic                 pf_in_frame = 1'b0;
  logic                 pf_esc      = 1'b0;
  logic [COUNT_W-1:0]   pf_cnt      = '0;
  logic [47:0]          pf_hdr      = '0;
  logic [47:0]          pf_ftr      = '0;

  dle_frame_receiver_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic frame_res_t make_res(kind_e k, logic [7:0] pb, logic [7:0] pi,
                                          logic [47:0] hdr, logic fv, logic [47:0] fw);
    frame_res_t r;
    r.kind     = k;
    r.pay_byte = pb;
    r.pay_idx  = pi;
    r.src      = hdr[47:40];
    r.dst      = hdr[39:32];
    r.ptype    = hdr[31:24];
    r.pstat    = hdr[23:16];
    r.seq      = hdr[15:8];
    r.plen     = hdr[7:0];
    r.fvalid   = fv;
    r.fword    = fw;
    return r;
  endfunction

  task automatic take_byte(input logic [7:0] b, output bit got, output frame_res_t r);
    int         rel;
    logic [7:0] len;
    got = 1'b0;
    r   = make_res(KIND_PAYLOAD, '0, '0, '0, 1'b0, '0);
    if (int'(pf_cnt) < int'(HEADER_BYTES)) begin
      pf_hdr[8*(HEADER_BYTES-1-pf_cnt) +: 8] = b;
      pf_cnt++;
    end else begin
      len = pf_hdr[7:0];
      rel = int'(pf_cnt) - int'(HEADER_BYTES);
      if (rel < int'(len)) begin
        got = 1'b1;
        r   = make_res(KIND_PAYLOAD, b, rel[7:0], pf_hdr, 1'b0, '0);
        pf_cnt++;
      end else if (len != 0 && rel - int'(len) < int'(FOOTER_BYTES) &&
                   int'(pf_cnt) < int'(HEADER_BYTES + 255 + FOOTER_BYTES)) begin
        pf_ftr = {pf_ftr[39:0], b};
        pf_cnt++;
      end
    end
  endtask

  task automatic step_deframer(input logic [7:0] b, output bit got, output frame_res_t r);
    logic [7:0] len;
    int         nfoot;
    got = 1'b0;
    r   = make_res(KIND_PAYLOAD, '0, '0, '0, 1'b0, '0);
    if (pf_esc) begin
      pf_esc = 1'b0;
      if (b == SYM_STX) begin
        pf_in_frame = 1'b1;
        pf_cnt      = '0;
        pf_hdr      = '0;
        pf_ftr      = '0;
      end else if (pf_in_frame) begin
        if (b == SYM_DLE) begin
          take_byte(b, got, r);
        end else if (b == SYM_ETX) begin
          pf_in_frame = 1'b0;
          got         = 1'b1;
          if (int'(pf_cnt) < int'(HEADER_BYTES)) begin
            r = make_res(KIND_SHORT_HEADER, '0, '0, pf_hdr, 1'b0, '0);
          end else begin
            len   = pf_hdr[7:0];
            nfoot = (len == 0 || int'(pf_cnt) <= int'(HEADER_BYTES) + int'(len)) ? 0 :
                    int'(pf_cnt) - int'(HEADER_BYTES) - int'(len);
            if (nfoot > 0 && nfoot < int'(FOOTER_BYTES))
              r = make_res(KIND_PART_FOOTER, '0, '0, pf_hdr, 1'b0, '0);
            else if (nfoot >= int'(FOOTER_BYTES))
              r = make_res(KIND_DONE, '0, '0, pf_hdr, 1'b1, pf_ftr);
            else
              r = make_res(KIND_DONE, '0, '0, pf_hdr, 1'b0, '0);
          end
        end else begin
          pf_in_frame = 1'b0;
          got         = 1'b1;
          r           = make_res(KIND_BAD_ESCAPE, '0, '0, pf_hdr, 1'b0, '0);
        end
      end
    end else if (b == SYM_DLE) begin
      pf_esc = 1'b1;
    end else if (pf_in_frame) begin
      take_byte(b, got, r);
    end
  endtask

  task automatic add_row(logic [7:0] b);
    stim_row_t row;
    row.rx    = b;
    row.typed = 1'b0;
    row.res   = make_res(KIND_PAYLOAD, '0, '0, '0, 1'b0, '0);
    byte_q.push_back(row);
  endtask

  task automatic add_typed(logic [7:0] b, frame_res_t res);
    stim_row_t row;
    row.rx    = b;
    row.typed = 1'b1;
    row.res   = res;
    byte_q.push_back(row);
  endtask

  task automatic add_data(logic [7:0] b);
    if (b == SYM_DLE)
      add_row(SYM_DLE);
    add_row(b);
  endtask

  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 4))
        0: b = SYM_DLE;
        1: b = SYM_STX;
        2: b = SYM_ETX;
        3: b = 8'h00;
        default: b = 8'hFF;
      endcase
    end
    return b;
  endfunction

  task automatic gen_frame();
    int         sel;
    int         len;
    int         total;
    int         cut;
    int         bad_at;
    int         restart_at;
    logic [7:0] b;
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 3) == 0) begin
          do b = 8'($urandom); while (b == SYM_DLE || b == SYM_STX);
          add_row(SYM_DLE);
          add_row(b);
        end else begin
          do b = 8'($urandom); while (b == SYM_DLE);
          add_row(b);
        end
      end
      return;
    end
    sel = $urandom_range(0, 99);
    if (sel < 2)
      len = $urandom_range(200, 255);
    else if (sel < 30)
      len = $urandom_range(9, 40);
    else
      len = $urandom_range(0, 8);
    total      = HEADER_BYTES + len + FOOTER_BYTES;
    total     += ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    cut        = total;
    bad_at     = -1;
    restart_at = -1;
    sel        = $urandom_range(0, 99);
    if (sel < 8)
      cut = $urandom_range(0, HEADER_BYTES - 1);
    else if (sel < 16 && len > 0)
      cut = HEADER_BYTES + $urandom_range(0, len - 1);
    else if (sel < 26 && len > 0)
      cut = HEADER_BYTES + len + $urandom_range(1, FOOTER_BYTES - 1);
    else if (sel < 32)
      bad_at = $urandom_range(0, total - 1);
    else if (sel < 37)
      restart_at = $urandom_range(0, total - 1);
    add_row(SYM_DLE);
    add_row(SYM_STX);
    for (int i = 0; i < cut; i++) begin
      if (i == bad_at) begin
        do b = 8'($urandom); while (b == SYM_DLE || b == SYM_STX || b == SYM_ETX);
        add_row(SYM_DLE);
        add_row(b);
        return;
      end
      if (i == restart_at) begin
        add_row(SYM_DLE);
        add_row(SYM_STX);
      end
      add_data((i == HEADER_BYTES - 1) ? len[7:0] : rand_byte());
    end
    add_row(SYM_DLE);
    add_row(SYM_ETX);
  endtask

  task automatic chk(string name, logic [47:0] want, logic [47:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    bit         got;
    frame_res_t res;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        step_deframer(cur_row.rx, got, res);
        if (cur_row.typed)
          frame_res_q.push_back(cur_row.res);
        else if (got)
          frame_res_q.push_back(res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_res_q.size() == 0) begin
          err_cnt++;
          $display("%0t unexpected word: expected none got kind %0d tdata %0h",
                   $time, m_axis_tuser, m_axis_tdata);
        end else begin
          res = frame_res_q.pop_front();
          chk("kind",          48'(res.kind),     48'(m_axis_tuser));
          chk("payload_byte",  48'(res.pay_byte), 48'(m_axis_tdata[7:0]));
          chk("payload_index", 48'(res.pay_idx),  48'(m_axis_tdata[15:8]));
          chk("src_addr",      48'(res.src),      48'(m_axis_tdata[23:16]));
          chk("dst_addr",      48'(res.dst),      48'(m_axis_tdata[31:24]));
          chk("pkt_type",      48'(res.ptype),    48'(m_axis_tdata[39:32]));
          chk("pkt_status",    48'(res.pstat),    48'(m_axis_tdata[47:40]));
          chk("seq_num",       48'(res.seq),      48'(m_axis_tdata[55:48]));
          chk("payload_len",   48'(res.plen),     48'(m_axis_tdata[63:56]));
          chk("footer_valid",  48'(res.fvalid),   48'(m_axis_tdata[64]));
          chk("footer_word",   res.fword,         m_axis_tdata[112:65]);
        end
      end
    end
  end

  initial begin : sink
    int hold_cnt;
    int phase_cnt;
    int rx_mode;
    int cyc;
    hold_cnt  = 0;
    phase_cnt = 0;
    rx_mode   = 0;
    cyc       = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (hold_req != 0) begin
        hold_req = 0;
        hold_cnt = 400;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= ((cyc % 7) < 4);
          default: m_axis_tready <= 1'($urandom_range(0, 1));
        endcase
      end
      phase_cnt++;
      if (phase_cnt == 150) begin
        phase_cnt = 0;
        rx_mode   = $urandom_range(0, 3);
      end
    end
  end

  initial begin : source
    int dir_len;
    int burst_left;
    add_row(SYM_DLE);
    add_row(SYM_ETX);
    add_row(SYM_DLE);
    add_row(SYM_STX);
    add_row(SYM_DLE);
    add_typed(SYM_ETX, make_res(KIND_SHORT_HEADER, '0, '0, '0, 1'b0, '0));
    add_row(SYM_DLE);
    add_row(SYM_STX);
    add_row(SYM_DLE);
    add_typed(8'h7F, make_res(KIND_BAD_ESCAPE, '0, '0, '0, 1'b0, '0));
    add_row(SYM_DLE);
    add_row(SYM_STX);
    add_row(8'hFF);
    add_row(SYM_DLE);
    add_row(SYM_STX);
    add_row(8'hFF);
    add_row(8'h00);
    add_data(SYM_DLE);
    add_row(SYM_STX);
    add_row(8'hAA);
    add_row(8'h00);
    add_row(8'h55);
    add_row(SYM_DLE);
    add_typed(SYM_ETX, make_res(KIND_DONE, '0, '0, 48'hFF00_1002_AA00, 1'b0, '0));
    dir_len = byte_q.size();
    while (byte_q.size() < 1150)
      gen_frame();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst_left = $urandom_range(1, 24);
    for (int i = 0; i < byte_q.size(); i++) begin
      if (i == dir_len + 60 || i == dir_len + 600)
        hold_req = 1;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ((i / 150) % 4 != 3) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= byte_q[i].rx;
      cur_row       <= byte_q[i];
      do @(posedge clk_i); while (!s_axis_tready);
      burst_left--;
    end
    s_axis_tvalid <= 1'b0;

    while (frame_res_q.size() != 0)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (err_cnt == 0 && frame_res_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
